>>> rtl/lfu_cache_replacement_defines.svh
// Assertion macros for the LFU cache block.
`ifndef LFU_CACHE_REPLACEMENT_DEFINES_SVH
`define LFU_CACHE_REPLACEMENT_DEFINES_SVH
// Check that an antecedent implies a consequent on the same edge.
`define LFU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that an antecedent implies a consequent on the next edge.
`define LFU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache block.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam logic [0:0] REQ_GET = 1'b0;
  localparam logic [0:0] REQ_PUT = 1'b1;
  localparam logic [0:0] REG_CAPACITY = 1'b0;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        req_type;
    logic [31:0] lookup_key;
    logic signed [31:0] write_value;
  } lfu_in_t;

  typedef struct packed {
    logic        hit;
    logic signed [31:0] read_value;
    logic        evicted;
  } lfu_out_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] count;
    logic [31:0] stamp;
  } lfu_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    lfu_entry_t       wdata;
    logic [IDX_W-1:0] raddr;
  } lfu_mem_req_t;
endpackage
`default_nettype wire

>>> rtl/lfu_cache_replacement.sv
// Top level of the LFU cache with LRU tie break.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_cache_replacement_defines.svh"
// Each item scans the entry memory one entry per cycle through its single
// read port, then writes any updated entry back and registers the result. The
// result sits in an output register and the input stays stalled until it
// leaves, so a new item is taken only once the last result has been accepted.
// Valid bits are flip-flops cleared at reset; no clearing pass is needed.
module lfu_cache_replacement
  import lfu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire lfu_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output lfu_out_t         out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [ENTRIES-1:0] valid_r;
  logic [OCC_W-1:0]   occ_r;
  logic [31:0]        stamp_r;
  lfu_in_t            req_r;
  logic [IDX_W:0]     cnt_r;
  logic [IDX_W-1:0]   ridx_r;
  logic               found_r;
  logic [IDX_W-1:0]   found_idx_r;
  lfu_entry_t         found_ent_r;
  logic               vic_ok_r;
  logic [IDX_W-1:0]   vic_idx_r;
  logic [31:0]        vic_cnt_r, vic_age_r;
  logic               free_ok_r;
  logic [IDX_W-1:0]   free_idx_r;
  lfu_out_t           out_r;
  logic               out_valid_r;
  lfu_mem_req_t       mreq;
  lfu_entry_t         rdata;
  logic [OCC_W-1:0]   eff_cap;
  logic               start, cfg_we, rd_valid;
  logic [31:0]        age;
  logic [IDX_W-1:0]   cur_idx;
  logic [IDX_W-1:0]   slot;
  logic               do_evict;

  lfu_store u_store (.clk(clk), .req(mreq), .rdata(rdata));

  assign pready = 1'b1;
  assign prdata = {{(32-CAP_W){1'b0}}, cap_r};
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_comb begin
    if (cap_r == '0) eff_cap = OCC_W'(1);
    else if ({{(32-CAP_W){1'b0}}, cap_r} > 32'(ENTRIES)) eff_cap = OCC_W'(ENTRIES);
    else eff_cap = OCC_W'(cap_r);
  end

  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign start     = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // entry read issued at cnt-1 arrives when cnt in 1..ENTRIES
  assign rd_valid = (state_r == ST_SCAN) && (cnt_r != '0);
  assign cur_idx  = ridx_r;
  assign age      = stamp_r - rdata.stamp;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SCAN;
      ST_SCAN: if (cnt_r == (IDX_W+1)'(ENTRIES)) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mreq.raddr = (state_r == ST_SCAN && cnt_r < (IDX_W+1)'(ENTRIES)) ?
                 cnt_r[IDX_W-1:0] : '0;
    mreq.we    = 1'b0;
    mreq.waddr = '0;
    mreq.wdata = found_ent_r;
    do_evict   = 1'b0;
    slot       = '0;
    if (state_r == ST_DONE) begin
      if (found_r) begin
        mreq.we = 1'b1;
        mreq.waddr = found_idx_r;
        mreq.wdata.count = (found_ent_r.count == COUNT_MAX) ? COUNT_MAX :
                           found_ent_r.count + 32'd1;
        mreq.wdata.stamp = stamp_r;
        if (req_r.req_type == REQ_PUT) mreq.wdata.value = req_r.write_value;
      end else if (req_r.req_type == REQ_PUT) begin
        mreq.we = 1'b1;
        if (occ_r < eff_cap && free_ok_r) slot = free_idx_r;
        else if (vic_ok_r) begin
          slot = vic_idx_r;
          do_evict = 1'b1;
        end
        mreq.waddr = slot;
        mreq.wdata.key = req_r.lookup_key;
        mreq.wdata.value = req_r.write_value;
        mreq.wdata.count = 32'd1;
        mreq.wdata.stamp = stamp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cap_r <= CAP_W'(16);
      valid_r <= '0;
      occ_r <= '0;
      stamp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= pwdata[CAP_W-1:0];
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_DONE) begin
        out_valid_r <= 1'b1;
        if (found_r || req_r.req_type == REQ_PUT) stamp_r <= stamp_r + 32'd1;
        if (!found_r && req_r.req_type == REQ_PUT) begin
          valid_r[slot] <= 1'b1;
          if (!do_evict) occ_r <= occ_r + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req_r <= in_data;
      cnt_r <= '0;
      found_r <= 1'b0;
      vic_ok_r <= 1'b0;
      free_ok_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      cnt_r <= cnt_r + (IDX_W+1)'(1);
      ridx_r <= mreq.raddr;
      if (rd_valid) begin
        if (valid_r[cur_idx]) begin
          if (!found_r && rdata.key == req_r.lookup_key) begin
            found_r <= 1'b1;
            found_idx_r <= cur_idx;
            found_ent_r <= rdata;
          end
          if (!vic_ok_r || rdata.count < vic_cnt_r ||
              (rdata.count == vic_cnt_r && age > vic_age_r)) begin
            vic_ok_r <= 1'b1;
            vic_idx_r <= cur_idx;
            vic_cnt_r <= rdata.count;
            vic_age_r <= age;
          end
        end else if (!free_ok_r) begin
          free_ok_r <= 1'b1;
          free_idx_r <= cur_idx;
        end
      end
    end
    if (state_r == ST_DONE) begin
      out_r.hit <= found_r;
      out_r.evicted <= do_evict;
      if (req_r.req_type == REQ_PUT) out_r.read_value <= '0;
      else if (found_r) out_r.read_value <= found_ent_r.value;
      else out_r.read_value <= MISS_VALUE;
    end
  end

  `LFU_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, in_stall,
    "item accepted while busy")
  `LFU_ASSERT_NXT(a_done_result, clk, rst_n, state_r == ST_DONE, out_valid_r,
    "no result after scan")
  `LFU_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OCC_W'(ENTRIES),
    "occupancy above entry count")
endmodule
`default_nettype wire

>>> rtl/lfu_store.sv
// Entry memory holding key, value, use count and last-use stamp.
`timescale 1ns / 1ps
`default_nettype none
module lfu_store
  import lfu_pkg::*;
(
  input  wire logic         clk,
  input  wire lfu_mem_req_t req,
  output lfu_entry_t        rdata
);
  lfu_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

>>> tb/sv/lfu_cache_replacement_test.sv
// Self-checking testbench for the LFU cache with LRU tie break.
`timescale 1ns / 1ps
module lfu_cache_replacement_test;
  import lfu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  lfu_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lfu_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lfu_cache_replacement dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor copy of the cache
  logic              slot_valid [ENTRIES];
  logic [31:0]       slot_key   [ENTRIES];
  logic [31:0]       slot_value [ENTRIES];
  logic [31:0]       slot_count [ENTRIES];
  logic [31:0]       slot_stamp [ENTRIES];
  logic [31:0]       stamp_now = '0;
  int unsigned       fill = 0;
  logic [CAP_W-1:0]  cap_reg = 5'd16;

  lfu_out_t    pending_results [$];
  int          errors = 0;
  int          burst_left = 0;
  logic [31:0] key_pool [24];

  initial begin
    for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
  end

  function automatic void bump(int i);
    if (slot_count[i] != COUNT_MAX) slot_count[i] = slot_count[i] + 1;
    slot_stamp[i] = stamp_now;
    stamp_now = stamp_now + 1;
  endfunction

  function automatic lfu_out_t cache_lookup(lfu_in_t it);
    lfu_out_t    r;
    int          found;
    int          slot;
    int unsigned lim;
    logic [31:0] best_cnt;
    logic [31:0] best_age;
    logic [31:0] age;
    r = '0;
    found = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == it.lookup_key) found = i;
    if (it.req_type == REQ_GET) begin
      if (found >= 0) begin
        r.hit = 1'b1;
        r.read_value = slot_value[found];
        bump(found);
      end else begin
        r.read_value = MISS_VALUE;
      end
      return r;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      slot_value[found] = it.write_value;
      bump(found);
      return r;
    end
    lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
    slot = -1;
    if (fill < lim)
      for (int i = 0; i < ENTRIES; i++)
        if (slot < 0 && !slot_valid[i]) slot = i;
    if (slot >= 0) begin
      fill++;
    end else begin
      best_cnt = '0;
      best_age = '0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i]) begin
          age = stamp_now - slot_stamp[i];
          if (slot < 0 || slot_count[i] < best_cnt ||
              (slot_count[i] == best_cnt && age > best_age)) begin
            slot = i;
            best_cnt = slot_count[i];
            best_age = age;
          end
        end
      end
      if (slot < 0) begin
        slot = 0;
        fill++;
      end else begin
        r.evicted = 1'b1;
      end
    end
    slot_valid[slot] = 1'b1;
    slot_key[slot] = it.lookup_key;
    slot_value[slot] = it.write_value;
    slot_count[slot] = 32'd1;
    slot_stamp[slot] = stamp_now;
    stamp_now = stamp_now + 1;
    return r;
  endfunction

  task automatic send_req(lfu_in_t it, bit typed, lfu_out_t want);
    int       gap;
    lfu_out_t got;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    got = cache_lookup(it);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(REG_CAPACITY) << 2;
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = v[CAP_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic lfu_in_t mk(logic [0:0] op, logic [31:0] k, logic [31:0] v);
    lfu_in_t it;
    it.req_type = op;
    it.lookup_key = k;
    it.write_value = v;
    return it;
  endfunction

  function automatic lfu_out_t res(logic h, logic [31:0] v, logic e);
    lfu_out_t r;
    r.hit = h;
    r.read_value = v;
    r.evicted = e;
    return r;
  endfunction

  typedef struct {
    lfu_in_t  req;
    bit       typed;
    lfu_out_t want;
  } stim_row_t;

  stim_row_t directed_rows [$];

  // result check
  always @(posedge clk) begin
    lfu_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: %h", out_data);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.hit !== exp_r.hit) begin
          $error("hit: expected %0d, got %0d", exp_r.hit, out_data.hit);
          errors++;
        end
        if (out_data.read_value !== exp_r.read_value) begin
          $error("read_value: expected %h, got %h", exp_r.read_value, out_data.read_value);
          errors++;
        end
        if (out_data.evicted !== exp_r.evicted) begin
          $error("evicted: expected %0d, got %0d", exp_r.evicted, out_data.evicted);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (cyc >= 3000 && cyc < 3400) out_stall <= 1'b1;
      else if (mode == 0) out_stall <= 1'b0;
      else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
      else if (mode == 2) out_stall <= ($urandom_range(0, 1) == 0);
      else out_stall <= (cyc % 7 < 4);
    end
  end

  initial begin
    int caps [8];
    int pick;
    lfu_in_t it;
    caps = '{1, 0, 31, 16, 4, 2, 17, 8};
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 24; i++) key_pool[i] = $urandom;

    directed_rows.push_back('{mk(REQ_GET, 32'h0, 32'h0), 1, res(0, MISS_VALUE, 0)});
    directed_rows.push_back('{mk(REQ_PUT, 32'h0, 32'h8000_0000), 1, res(0, 0, 0)});
    directed_rows.push_back('{mk(REQ_GET, 32'h0, 32'h0), 1, res(1, 32'h8000_0000, 0)});
    directed_rows.push_back('{mk(REQ_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF), 1, res(0, 0, 0)});
    directed_rows.push_back('{mk(REQ_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                              res(1, 32'h7FFF_FFFF, 0)});
    directed_rows.push_back('{mk(REQ_PUT, 32'h0, 32'hFFFF_FFFF), 1, res(1, 0, 0)});
    directed_rows.push_back('{mk(REQ_GET, 32'h0, 32'h0), 1, res(1, MISS_VALUE, 0)});
    directed_rows.push_back('{mk(REQ_GET, 32'h1234_5678, 32'h0), 1, res(0, MISS_VALUE, 0)});
    for (int i = 0; i < 16; i++)
      directed_rows.push_back('{mk(REQ_PUT, 32'h100 + i, $urandom), 0, '0});
    directed_rows.push_back('{mk(REQ_GET, 32'h100, 32'h0), 0, '0});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      pick = (ph < 8) ? caps[ph] : $urandom_range(1, 16);
      write_capacity(pick);
      for (int n = 0; n < 75; n++) begin
        it.req_type = 1'($urandom_range(0, 1));
        it.lookup_key = ($urandom_range(0, 9) == 0) ? $urandom
                                                    : key_pool[$urandom_range(0, 23)];
        it.write_value = $urandom;
        send_req(it, 0, '0);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
